// File: hw/rtl/set_operations_engine_defines.svh
// Assertion macros for the set operations engine.
// Included by set_operations_engine.sv; no other dependencies.
`ifndef SET_OPERATIONS_ENGINE_DEFINES_SVH
`define SET_OPERATIONS_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SOE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("set_operations_engine: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SOE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("set_operations_engine: next-cycle check failed");

`endif

// File: hw/rtl/setops_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the set operations engine: opcodes and default sizes.
// No dependencies.
package setops_pkg;

    localparam int CAPACITY_DEF      = 32;
    localparam int ELEMENT_WIDTH_DEF = 32;

    localparam int OPCODE_W = 3;

    localparam logic [OPCODE_W-1:0] OP_LOAD_A = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_LOAD_B = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_EQUAL  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_UNION  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_ISECT  = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_DIFF   = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd6;

endpackage

// File: hw/rtl/set_operations_engine.sv
`timescale 1ns / 1ps
// Set operations engine top level: two set stores and the scan sequencer.
// Depends on setops_pkg and set_operations_engine_defines.svh.
//
// Usage:
//   Requests come in on in_valid/in_ready with opcode and element. Load A and
//   load B append element to a set (dropped when the set is full); clear
//   empties both sets. These give no result.
//   Equal, union, intersection and difference produce results on
//   out_valid/out_ready: value, sets_equal, empty_res, last. Equal gives one
//   result; the others give one result per element, or a single empty_res
//   result, with last on the final one.
//   Membership is found with one shared comparator walking the other set,
//   one stored element per cycle (registered memory reads). Union first
//   passes over every element of A, which it emits unchecked.
//   in_ready is low for the whole compute request.
//   A one-entry hold buffer keeps the newest kept element so the final
//   result can carry last. An output register separates the sequencer from
//   the receiver: when out_ready is low the scan stalls only when it needs to
//   hand over another result, and a new request is taken while the final
//   result still waits.
//   Reset clears both set counts and all control state; set memories are not
//   cleared and are only read below their counts.
`include "set_operations_engine_defines.svh"

module set_operations_engine
    import setops_pkg::*;
#(
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [OPCODE_W-1:0]             opcode,
    input  logic signed [ELEMENT_WIDTH-1:0] element,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [ELEMENT_WIDTH-1:0] value,
    output logic                            sets_equal,
    output logic                            empty_res,
    output logic                            last
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_OUTER  = 3'd1;  // fetch next element of the outer set
    localparam logic [2:0] S_LATCH  = 3'd2;  // outer element arrives
    localparam logic [2:0] S_SCAN   = 3'd3;  // walk the inner set
    localparam logic [2:0] S_PUSH   = 3'd4;  // kept element into hold buffer
    localparam logic [2:0] S_FINISH = 3'd5;  // final result

    // Set memories
    logic [ELEMENT_WIDTH-1:0] mem_a [CAPACITY];
    logic [ELEMENT_WIDTH-1:0] mem_b [CAPACITY];
    logic [ELEMENT_WIDTH-1:0] a_rd_reg, b_rd_reg;

    logic [2:0]          state_reg, state_next;
    logic [OPCODE_W-1:0] op_reg, op_next;
    logic                phase_reg, phase_next;   // 1: union second pass, B outer
    logic [CNT_W-1:0]    cnt_a_reg, cnt_a_next;
    logic [CNT_W-1:0]    cnt_b_reg, cnt_b_next;
    logic [CNT_W-1:0]    i_reg, i_next;
    logic [CNT_W-1:0]    j_reg, j_next;
    logic                cmp_v_reg, cmp_v_next;
    logic                eq_reg, eq_next;
    logic [ELEMENT_WIDTH-1:0] key_reg, key_next;
    logic [ELEMENT_WIDTH-1:0] cand_reg, cand_next;
    logic [ELEMENT_WIDTH-1:0] pend_reg, pend_next;
    logic                pend_v_reg, pend_v_next;

    logic                out_valid_reg, out_valid_next;
    logic [ELEMENT_WIDTH-1:0] value_reg, value_next;
    logic                eq_out_reg, eq_out_next;
    logic                empty_reg, empty_next;
    logic                last_reg, last_next;

    logic                in_fire;
    logic                we_a, we_b;
    logic                rd_x_en, rd_y_en;
    logic                rd_a_en, rd_b_en;
    logic [ADDR_W-1:0]   rd_a_addr, rd_b_addr;
    logic [CNT_W-1:0]    x_cnt, y_cnt;
    logic [ELEMENT_WIDTH-1:0] x_rd, y_rd;
    logic                hit, miss_done, found, keep, slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // Outer set is A except on the union second pass.
    assign x_cnt = phase_reg ? cnt_b_reg : cnt_a_reg;
    assign y_cnt = phase_reg ? cnt_a_reg : cnt_b_reg;
    assign x_rd  = phase_reg ? b_rd_reg : a_rd_reg;
    assign y_rd  = phase_reg ? a_rd_reg : b_rd_reg;

    assign hit       = cmp_v_reg && (y_rd == key_reg);
    assign miss_done = !hit && (j_reg == y_cnt);
    assign found     = hit;
    assign keep      = (op_reg == OP_ISECT) ? found : !found;

    assign rd_x_en = (state_reg == S_OUTER) && (i_reg < x_cnt);
    assign rd_y_en = (state_reg == S_SCAN) && !hit && !miss_done;

    assign rd_a_en   = phase_reg ? rd_y_en : rd_x_en;
    assign rd_b_en   = phase_reg ? rd_x_en : rd_y_en;
    assign rd_a_addr = phase_reg ? j_reg[ADDR_W-1:0] : i_reg[ADDR_W-1:0];
    assign rd_b_addr = phase_reg ? i_reg[ADDR_W-1:0] : j_reg[ADDR_W-1:0];

    assign we_a = in_fire && (opcode == OP_LOAD_A) && (cnt_a_reg < CAP_CNT);
    assign we_b = in_fire && (opcode == OP_LOAD_B) && (cnt_b_reg < CAP_CNT);

    always_ff @(posedge clk)
    begin
        if (we_a)
        begin
            mem_a[cnt_a_reg[ADDR_W-1:0]] <= element;
        end
        if (we_b)
        begin
            mem_b[cnt_b_reg[ADDR_W-1:0]] <= element;
        end
        if (rd_a_en)
        begin
            a_rd_reg <= mem_a[rd_a_addr];
        end
        if (rd_b_en)
        begin
            b_rd_reg <= mem_b[rd_b_addr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        phase_next     = phase_reg;
        cnt_a_next     = cnt_a_reg;
        cnt_b_next     = cnt_b_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        cmp_v_next     = cmp_v_reg;
        eq_next        = eq_reg;
        key_next       = key_reg;
        cand_next      = cand_reg;
        pend_next      = pend_reg;
        pend_v_next    = pend_v_reg;
        out_valid_next = out_valid_reg && !out_ready;
        value_next     = value_reg;
        eq_out_next    = eq_out_reg;
        empty_next     = empty_reg;
        last_next      = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    op_next    = opcode;
                    phase_next = 1'b0;
                    i_next     = '0;
                    unique case (opcode)
                        OP_LOAD_A:
                        begin
                            if (we_a)
                            begin
                                cnt_a_next = cnt_a_reg + CNT_W'(1);
                            end
                        end
                        OP_LOAD_B:
                        begin
                            if (we_b)
                            begin
                                cnt_b_next = cnt_b_reg + CNT_W'(1);
                            end
                        end
                        OP_CLEAR:
                        begin
                            cnt_a_next = '0;
                            cnt_b_next = '0;
                        end
                        OP_EQUAL:
                        begin
                            eq_next    = (cnt_a_reg == cnt_b_reg);
                            state_next = (cnt_a_reg == cnt_b_reg) ? S_OUTER : S_FINISH;
                        end
                        OP_UNION, OP_ISECT, OP_DIFF:
                        begin
                            state_next = S_OUTER;
                        end
                        default:
                        begin
                            // undefined opcode: no effect
                        end
                    endcase
                end
            end

            S_OUTER:
            begin
                if (i_reg < x_cnt)
                begin
                    state_next = S_LATCH;
                end
                else if (op_reg == OP_UNION && !phase_reg)
                begin
                    phase_next = 1'b1;
                    i_next     = '0;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_LATCH:
            begin
                key_next   = x_rd;
                cand_next  = x_rd;
                j_next     = '0;
                cmp_v_next = 1'b0;
                // union first pass emits every element of A unchecked
                state_next = (op_reg == OP_UNION && !phase_reg) ? S_PUSH : S_SCAN;
            end

            S_SCAN:
            begin
                if (hit || miss_done)
                begin
                    cmp_v_next = 1'b0;
                    if (op_reg == OP_EQUAL)
                    begin
                        if (!found)
                        begin
                            eq_next    = 1'b0;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            i_next     = i_reg + CNT_W'(1);
                            state_next = S_OUTER;
                        end
                    end
                    else if (keep)
                    begin
                        state_next = S_PUSH;
                    end
                    else
                    begin
                        i_next     = i_reg + CNT_W'(1);
                        state_next = S_OUTER;
                    end
                end
                else
                begin
                    j_next     = j_reg + CNT_W'(1);
                    cmp_v_next = 1'b1;
                end
            end

            S_PUSH:
            begin
                if (!pend_v_reg)
                begin
                    pend_next   = cand_reg;
                    pend_v_next = 1'b1;
                    i_next      = i_reg + CNT_W'(1);
                    state_next  = S_OUTER;
                end
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    value_next     = pend_reg;
                    eq_out_next    = 1'b0;
                    empty_next     = 1'b0;
                    last_next      = 1'b0;
                    pend_next      = cand_reg;
                    i_next         = i_reg + CNT_W'(1);
                    state_next     = S_OUTER;
                end
            end

            S_FINISH:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    last_next      = 1'b1;
                    if (op_reg == OP_EQUAL)
                    begin
                        value_next  = '0;
                        eq_out_next = eq_reg;
                        empty_next  = 1'b0;
                    end
                    else if (pend_v_reg)
                    begin
                        value_next  = pend_reg;
                        eq_out_next = 1'b0;
                        empty_next  = 1'b0;
                    end
                    else
                    begin
                        value_next  = '0;
                        eq_out_next = 1'b0;
                        empty_next  = 1'b1;
                    end
                    pend_v_next = 1'b0;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_LOAD_A;
            phase_reg     <= 1'b0;
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            cmp_v_reg     <= 1'b0;
            eq_reg        <= 1'b0;
            pend_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            phase_reg     <= phase_next;
            cnt_a_reg     <= cnt_a_next;
            cnt_b_reg     <= cnt_b_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            cmp_v_reg     <= cmp_v_next;
            eq_reg        <= eq_next;
            pend_v_reg    <= pend_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        cand_reg   <= cand_next;
        pend_reg   <= pend_next;
        value_reg  <= value_next;
        eq_out_reg <= eq_out_next;
        empty_reg  <= empty_next;
        last_reg   <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign value      = value_reg;
    assign sets_equal = eq_out_reg;
    assign empty_res  = empty_reg;
    assign last       = last_reg;

    // Checks
    `SOE_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1,
        (cnt_a_reg <= CAP_CNT) && (cnt_b_reg <= CAP_CNT))
    `SOE_ASSERT_NEXT(a_compute_busy, clk, rst_n,
        in_fire && (opcode == OP_EQUAL || opcode == OP_UNION ||
                    opcode == OP_ISECT || opcode == OP_DIFF),
        !in_ready)
    `SOE_ASSERT_NOW(a_hold_drained, clk, rst_n, pend_v_reg, state_reg != S_IDLE)
    `SOE_ASSERT_NOW(a_empty_is_last, clk, rst_n, out_valid && empty_res,
        last && !sets_equal)

endmodule
